[sv/bup4_pkg.sv]
`default_nettype none

package bup4_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

    // reset values of the size registers
    localparam logic [CFG_DATA_W-1:0] RST_MAP_WIDTH  = 10'd512;
    localparam logic [CFG_DATA_W-1:0] RST_MAP_HEIGHT = 10'd512;

    // default line store and frame limits
    localparam int unsigned DEF_MAX_MAP_WIDTH  = 512;
    localparam int unsigned DEF_MAX_MAP_HEIGHT = 512;

    // output block position width and the row index of the last block row
    localparam int unsigned BLK_POS_W = 9;
    localparam logic [1:0]  LAST_ROW  = 2'd3;

    // smallest usable map size
    localparam int unsigned MIN_MAP_SIZE = 2;

    typedef struct packed {
        logic [31:0] map_color;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [31:0]          out_pixel_0;
        logic [31:0]          out_pixel_1;
        logic [31:0]          out_pixel_2;
        logic [31:0]          out_pixel_3;
        logic [BLK_POS_W-1:0] block_column;
        logic [BLK_POS_W-1:0] block_row;
        logic [1:0]           row_in_block;
        logic                 block_done;
    } t_out;

endpackage

`default_nettype wire

[sv/bilinear_upscale_4x4_blit_unit.sv]
`default_nettype none

// Bilinear 4x upscaler. Coarse ARGB map pixels enter in raster order; the previous
// map row sits in a line store memory (one read and one write port, registered read)
// and the left neighbour in a register. Each pixel that completes a map cell (column
// and row both at least one) yields four output transactions, the rows of the cell's
// 4x4 block, top to bottom. The interpolation stage produces one row per cycle, unless
// the output stalls, into a single output register, so a completing pixel holds that
// stage until its four rows are taken and the next completing pixel waits in the read
// stage; pixels in the first row or first column produce nothing and are taken one per
// cycle unless a pixel ahead waits. Rows pass the read and interpolation stages, then
// the output register. The line store is not cleared after reset: the first map row of
// a frame fills it, and sizes may be written only while the block is idle.
module bilinear_upscale_4x4_blit_unit #(
    parameter int unsigned MAX_MAP_WIDTH  = bup4_pkg::DEF_MAX_MAP_WIDTH,
    parameter int unsigned MAX_MAP_HEIGHT = bup4_pkg::DEF_MAX_MAP_HEIGHT
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // map pixel channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  bup4_pkg::t_in                  i_in,
    // output row channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output bup4_pkg::t_out                       o_out,
    // configuration write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [bup4_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [bup4_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned AW  = (MAX_MAP_WIDTH > 2) ? $clog2(MAX_MAP_WIDTH) : 1;
    localparam int unsigned PW  = $clog2(MAX_MAP_WIDTH + 1);
    localparam int unsigned PHW = $clog2(MAX_MAP_HEIGHT + 1);
    localparam int unsigned DW  = bup4_pkg::CFG_DATA_W;
    localparam int unsigned XW  = (PW > DW) ? PW : DW;
    localparam int unsigned XHW = (PHW > DW) ? PHW : DW;
    localparam int unsigned BW  = bup4_pkg::BLK_POS_W;
    localparam int unsigned XC  = (PW > BW) ? PW : BW;
    localparam int unsigned XR  = (PHW > BW) ? PHW : BW;

    // configuration registers
    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bup4_pkg::RST_MAP_WIDTH;
            r_height <= bup4_pkg::RST_MAP_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bup4_pkg::CFG_MAP_WIDTH:  r_width  <= i_cfg_data;
                bup4_pkg::CFG_MAP_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sizes clamped to the usable range
    logic [XW-1:0]  width_x;
    logic [XHW-1:0] height_x;
    logic [PW-1:0]  w_eff;
    logic [PHW-1:0] h_eff;

    assign width_x  = XW'(r_width);
    assign height_x = XHW'(r_height);
    assign w_eff = (r_width < DW'(bup4_pkg::MIN_MAP_SIZE)) ? PW'(bup4_pkg::MIN_MAP_SIZE) :
                   (width_x > XW'(MAX_MAP_WIDTH)) ? PW'(MAX_MAP_WIDTH) : PW'(width_x);
    assign h_eff = (r_height < DW'(bup4_pkg::MIN_MAP_SIZE)) ? PHW'(bup4_pkg::MIN_MAP_SIZE) :
                   (height_x > XHW'(MAX_MAP_HEIGHT)) ? PHW'(MAX_MAP_HEIGHT) : PHW'(height_x);

    // map position and left neighbour
    logic [PW-1:0]  r_col;
    logic [PHW-1:0] r_row;
    logic [31:0]    r_left;
    logic [PW-1:0]  cur_col;
    logic [PHW-1:0] cur_row;
    logic [PW-1:0]  n_col;
    logic [PHW-1:0] n_row;
    logic           cur_last;
    logic           cur_emit;
    logic           in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // position of the incoming pixel, then the position after it
    always_comb begin
        cur_col = i_in.frame_start ? '0 : r_col;
        cur_row = i_in.frame_start ? '0 : r_row;
        if (cur_col >= w_eff) begin
            cur_col = '0;
            cur_row = cur_row + PHW'(1);
        end
        if (cur_row >= h_eff) begin
            cur_row = '0;
        end
        cur_last = (cur_col + PW'(1)) >= w_eff;
        cur_emit = (cur_col != '0) && (cur_row != '0);
        n_col = cur_col + PW'(1);
        n_row = cur_row;
        if (cur_last) begin
            n_col = '0;
            n_row = cur_row + PHW'(1);
            if (n_row >= h_eff) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= i_in.map_color;
        end
    end

    // line store: left neighbour goes back at column - 1, last pixel of a row in the next cycle
    logic [31:0]   r_mem [MAX_MAP_WIDTH];
    logic [31:0]   r_q;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    logic [31:0]   r_pend_data;
    logic [AW-1:0] cur_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    assign cur_addr = cur_col[AW-1:0];
    assign mem_we   = r_pend || (in_acc && (cur_col != '0));
    assign mem_wa   = r_pend ? r_pend_addr : (cur_addr - AW'(1));
    assign mem_wd   = r_pend ? r_pend_data : r_left;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (in_acc) begin
            r_q <= r_mem[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= in_acc && cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend_addr <= cur_addr;
            r_pend_data <= i_in.map_color;
        end
    end

    // block position of the cell closed by this pixel
    logic [XC-1:0] col_m1;
    logic [XR-1:0] row_m1;

    assign col_m1 = XC'(cur_col) - XC'(1);
    assign row_m1 = XR'(cur_row) - XR'(1);

    // read stage: waits for the upper-row pixel
    logic          r_s1_valid;
    logic          r_s1_emit;
    logic [31:0]   r_s1_c;
    logic [31:0]   r_s1_d;
    logic [BW-1:0] r_s1_col;
    logic [BW-1:0] r_s1_row;
    logic [31:0]   r_prev_b;
    logic          s1_go;

    // interpolation stage: one block row per cycle while the output is not stalled
    logic          r_w_valid;
    logic [31:0]   r_w_a;
    logic [31:0]   r_w_b;
    logic [31:0]   r_w_c;
    logic [31:0]   r_w_d;
    logic [1:0]    r_w_j;
    logic [BW-1:0] r_w_col;
    logic [BW-1:0] r_w_row;
    logic          w_fire;
    logic          w_last;

    assign w_fire     = r_w_valid && (!o_out_valid || i_out_ready);
    assign w_last     = w_fire && (r_w_j == bup4_pkg::LAST_ROW);
    assign s1_go      = r_s1_valid && (!r_s1_emit || !r_w_valid || w_last);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_emit <= cur_emit;
            r_s1_c    <= r_left;
            r_s1_d    <= i_in.map_color;
            r_s1_col  <= col_m1[BW-1:0];
            r_s1_row  <= row_m1[BW-1:0];
        end
        // upper-right corner of one cell is the upper-left corner of the next
        if (s1_go) begin
            r_prev_b <= r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_w_j     <= '0;
        end else if (s1_go && r_s1_emit) begin
            r_w_valid <= 1'b1;
            r_w_j     <= '0;
        end else if (w_fire) begin
            r_w_valid <= !w_last;
            r_w_j     <= r_w_j + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_w_a   <= r_prev_b;
            r_w_b   <= r_q;
            r_w_c   <= r_s1_c;
            r_w_d   <= r_s1_d;
            r_w_col <= r_s1_col;
            r_w_row <= r_s1_row;
        end
    end

    // row j of the cell, in quarter steps: the Q15 values all carry a factor of 2^13,
    // so end points are 4*top + j*(bottom - top) and each pixel adds a quarter span
    logic [31:0] row_pix [4];

    always_comb begin
        logic signed [11:0] a_s;
        logic signed [11:0] b_s;
        logic signed [11:0] c_s;
        logic signed [11:0] d_s;
        logic signed [11:0] j_s;
        logic signed [11:0] lq;
        logic signed [11:0] rq;
        logic signed [11:0] span;
        logic signed [11:0] acc;
        logic signed [11:0] v;
        logic [7:0]         sat;
        for (int k = 0; k < 4; k++) begin
            row_pix[k] = '0;
        end
        for (int ch = 0; ch < 4; ch++) begin
            a_s  = signed'({4'b0, r_w_a[8*ch +: 8]});
            b_s  = signed'({4'b0, r_w_b[8*ch +: 8]});
            c_s  = signed'({4'b0, r_w_c[8*ch +: 8]});
            d_s  = signed'({4'b0, r_w_d[8*ch +: 8]});
            j_s  = signed'({10'b0, r_w_j});
            lq   = (a_s <<< 2) + j_s * (c_s - a_s);
            rq   = (b_s <<< 2) + j_s * (d_s - b_s);
            span = (rq - lq) >>> 2;
            for (int k = 0; k < 4; k++) begin
                acc = lq + signed'(12'(k)) * span;
                v   = acc >>> 2;
                if (v < 12'sd0) begin
                    sat = 8'd0;
                end else if (v > 12'sd255) begin
                    sat = 8'd255;
                end else begin
                    sat = v[7:0];
                end
                row_pix[k][8*ch +: 8] = sat;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_fire) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_out.out_pixel_0  <= row_pix[0];
            o_out.out_pixel_1  <= row_pix[1];
            o_out.out_pixel_2  <= row_pix[2];
            o_out.out_pixel_3  <= row_pix[3];
            o_out.block_column <= r_w_col;
            o_out.block_row    <= r_w_row;
            o_out.row_in_block <= r_w_j;
            o_out.block_done   <= (r_w_j == bup4_pkg::LAST_ROW);
        end
    end

endmodule

`default_nettype wire

[sv/bup4_checker.sv]
`default_nettype none

module bup4_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_out_valid,
    input wire                              i_out_ready,
    input wire bup4_pkg::t_out              o_out
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output transaction changed while stalled");

    // rows of one block follow without a gap once the previous row is taken
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_out.row_in_block != bup4_pkg::LAST_ROW)
        |=> o_out_valid
            && (o_out.row_in_block == $past(o_out.row_in_block) + 2'd1)
            && (o_out.block_column == $past(o_out.block_column))
            && (o_out.block_row == $past(o_out.block_row)))
        else $error("block rows out of sequence");

    // done flag marks the last row only
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.block_done == (o_out.row_in_block == bup4_pkg::LAST_ROW)))
        else $error("block_done disagrees with row_in_block");

    // nothing is offered straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind bilinear_upscale_4x4_blit_unit bup4_checker u_bup4_checker (.*);

`default_nettype wire

[tb/sv/bilinear_upscale_4x4_blit_unit_tb.sv]
`timescale 1ns / 1ps

module bilinear_upscale_4x4_blit_unit_tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_NS     = 10_000_000;
    localparam int RANDOM_PIXELS  = 420;
    localparam int WIDE_PIXELS    = 24;
    localparam int Q15_ONE        = 32768;
    localparam int QUARTER_STEP   = 8192;
    localparam int FRAC_BITS      = 15;
    localparam int CHANNEL_MAX    = 255;
    localparam int POS_W          = bup4_pkg::BLK_POS_W;

    // expected output rows of the upscaler, worked out per accepted map pixel
    class blit_scoreboard;
        logic [31:0]     line_store [bup4_pkg::DEF_MAX_MAP_WIDTH];
        bit              line_written [bup4_pkg::DEF_MAX_MAP_WIDTH];
        logic [31:0]     left_px;
        int unsigned     col_pos;
        int unsigned     row_pos;
        int unsigned     width_reg;
        int unsigned     height_reg;
        bup4_pkg::t_out  expected_rows [$];
        int unsigned     rows_checked;
        int unsigned     mismatches;

        function new();
            line_written = '{default: 1'b0};
            left_px      = '0;
            col_pos      = 0;
            row_pos      = 0;
            width_reg    = bup4_pkg::RST_MAP_WIDTH;
            height_reg   = bup4_pkg::RST_MAP_HEIGHT;
            rows_checked = 0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [bup4_pkg::CFG_IDX_W-1:0] idx,
                                   logic [bup4_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bup4_pkg::CFG_MAP_WIDTH: width_reg = data;
                bup4_pkg::CFG_MAP_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned maxv);
            if (v < bup4_pkg::MIN_MAP_SIZE)
                return bup4_pkg::MIN_MAP_SIZE;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        // position of the next pixel, after frame start and wrap rules
        function void locate(bit fs, output int unsigned c, output int unsigned r);
            int unsigned w;
            int unsigned h;
            w = clamp_size(width_reg, bup4_pkg::DEF_MAX_MAP_WIDTH);
            h = clamp_size(height_reg, bup4_pkg::DEF_MAX_MAP_HEIGHT);
            c = fs ? 0 : col_pos;
            r = fs ? 0 : row_pos;
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h)
                r = 0;
        endfunction

        // true if the pixel would read a line store entry never filled
        function bit reads_unwritten(bit fs);
            int unsigned c;
            int unsigned r;
            locate(fs, c, r);
            return c >= 1 && r >= 1 && (!line_written[c-1] || !line_written[c]);
        endfunction

        // one row of a 4x4 block, per channel in q15
        function bup4_pkg::t_out cell_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d, int j, int unsigned col,
                                          int unsigned row);
            int             av, bv, cv, dv;
            int             left_q, right_q, span, v;
            logic [31:0]    px [4];
            bup4_pkg::t_out res;
            px = '{default: '0};
            for (int ch = 0; ch < 4; ch++) begin
                av = a[8*ch +: 8];
                bv = b[8*ch +: 8];
                cv = c[8*ch +: 8];
                dv = d[8*ch +: 8];
                left_q  = av * Q15_ONE + j * (cv - av) * QUARTER_STEP;
                right_q = bv * Q15_ONE + j * (dv - bv) * QUARTER_STEP;
                span    = (right_q - left_q) >>> FRAC_BITS;
                for (int k = 0; k < 4; k++) begin
                    v = (left_q + k * span * QUARTER_STEP) >>> FRAC_BITS;
                    if (v < 0)
                        v = 0;
                    if (v > CHANNEL_MAX)
                        v = CHANNEL_MAX;
                    px[k][8*ch +: 8] = v[7:0];
                end
            end
            res.out_pixel_0  = px[0];
            res.out_pixel_1  = px[1];
            res.out_pixel_2  = px[2];
            res.out_pixel_3  = px[3];
            res.block_column = POS_W'(col - 1);
            res.block_row    = POS_W'(row - 1);
            res.row_in_block = 2'(j);
            res.block_done   = (2'(j) == bup4_pkg::LAST_ROW);
            return res;
        endfunction

        // accepted map pixel: predict its rows and advance the line store
        function void note_pixel(bup4_pkg::t_in px);
            int unsigned c;
            int unsigned r;
            int unsigned w;
            int unsigned h;
            w = clamp_size(width_reg, bup4_pkg::DEF_MAX_MAP_WIDTH);
            h = clamp_size(height_reg, bup4_pkg::DEF_MAX_MAP_HEIGHT);
            locate(px.frame_start, c, r);
            if (c >= 1 && r >= 1)
                for (int j = 0; j < 4; j++)
                    expected_rows.push_back(cell_row(line_store[c-1], line_store[c],
                                                     left_px, px.map_color, j, c, r));
            if (c >= 1) begin
                line_store[c-1]   = left_px;
                line_written[c-1] = 1'b1;
            end
            if (c + 1 >= w) begin
                line_store[c]   = px.map_color;
                line_written[c] = 1'b1;
            end
            left_px = px.map_color;
            col_pos = c + 1;
            row_pos = r;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // accepted output row against the oldest expectation
        function void check_row(bup4_pkg::t_out got);
            bup4_pkg::t_out want;
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected output row, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_rows.pop_front();
            rows_checked++;
            compare_field("out_pixel_0", want.out_pixel_0, got.out_pixel_0);
            compare_field("out_pixel_1", want.out_pixel_1, got.out_pixel_1);
            compare_field("out_pixel_2", want.out_pixel_2, got.out_pixel_2);
            compare_field("out_pixel_3", want.out_pixel_3, got.out_pixel_3);
            compare_field("block_column", want.block_column, got.block_column);
            compare_field("block_row", want.block_row, got.block_row);
            compare_field("row_in_block", want.row_in_block, got.row_in_block);
            compare_field("block_done", want.block_done, got.block_done);
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    bup4_pkg::t_in                   in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    bup4_pkg::t_out                  out_row;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bup4_pkg::CFG_IDX_W-1:0]  cfg_index = bup4_pkg::CFG_MAP_WIDTH;
    logic [bup4_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    blit_scoreboard sb;
    logic [15:0]    stall_pattern = 16'hFFFF;
    logic [3:0]     stall_phase   = '0;
    bit             sender_gappy  = 1'b0;
    int unsigned    gap_max       = 1;
    int unsigned    burst_left    = 0;
    int unsigned    pixels_sent   = 0;
    int unsigned    size_settings = 0;

    bilinear_upscale_4x4_blit_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_row),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // output side: check each transaction, stall on a rotating pattern
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_row(out_row);
        out_ready   <= stall_pattern[stall_phase];
        stall_phase <= stall_phase + 4'd1;
    end

    // new sender burst shape and receiver stall pattern
    task automatic pick_idling();
        sender_gappy  = $urandom_range(0, 3) != 0;
        gap_max       = $urandom_range(1, 6);
        burst_left    = 0;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    endtask

    task automatic write_sizes(input logic [bup4_pkg::CFG_DATA_W-1:0] width,
                               input logic [bup4_pkg::CFG_DATA_W-1:0] height);
        cfg_valid <= 1'b1;
        cfg_index <= bup4_pkg::CFG_MAP_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(bup4_pkg::CFG_MAP_WIDTH, width);
        cfg_index <= bup4_pkg::CFG_MAP_HEIGHT;
        cfg_data  <= height;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(bup4_pkg::CFG_MAP_HEIGHT, height);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // one map pixel transaction, with a random gap between bursts when the sender is gappy
    task automatic send_pixel(input logic [31:0] colour, input bit fs);
        bup4_pkg::t_in px;
        if (sender_gappy && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max))
                @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0)
            burst_left--;
        // never let a cell read a line store entry that was never filled
        px.map_color   = colour;
        px.frame_start = fs || sb.reads_unwritten(fs);
        in_valid <= 1'b1;
        in_item  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    // wait until every expected row is out and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_colour();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                for (int ch = 0; ch < 4; ch++)
                    c[8*ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            1: begin
                for (int ch = 0; ch < 4; ch++)
                    c[8*ch +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                        : 8'($urandom_range(252, 255));
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        logic [31:0]                     corner_colours [11];
        logic [31:0]                     wrap_colours [8];
        logic [bup4_pkg::CFG_DATA_W-1:0] width_sel;
        logic [bup4_pkg::CFG_DATA_W-1:0] height_sel;
        int unsigned                     phase_len;
        int unsigned                     random_start;

        sb = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme colours on a 4x3 map, ending part way into the last row
        corner_colours = '{32'h00000000, 32'hFFFFFFFF, 32'h00FF00FF, 32'hFF00FF00,
                           32'hFFFFFFFF, 32'h00000000, 32'hFF00FF00, 32'h00FF00FF,
                           32'h80808080, 32'h7F7F7F7F, 32'h01FE01FE};
        pick_idling();
        write_sizes(10'd4, 10'd3);
        foreach (corner_colours[i])
            send_pixel(corner_colours[i], i == 0);
        settle();

        // sizes below the minimum, old position beyond the shrunken map,
        // a frame start that cuts a cell and the wrap at frame end
        wrap_colours = '{32'h12345678, 32'hFEDCBA98, 32'h00000000, 32'hFFFFFFFF,
                         32'h0F0F0F0F, 32'hF0F0F0F0, 32'hA5A55A5A, 32'h5A5AA5A5};
        pick_idling();
        write_sizes(10'd1, 10'd0);
        foreach (wrap_colours[i])
            send_pixel(wrap_colours[i], i == 3);
        settle();

        // sizes above the maximum, start of the first row of the widest map
        pick_idling();
        write_sizes(10'd700, 10'd1023);
        for (int i = 0; i < WIDE_PIXELS; i++)
            send_pixel(random_colour(), i == 0);
        settle();

        // random sizes and content
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            case ($urandom_range(0, 19))
                0, 1: width_sel = $urandom_range(0, 1);
                2, 3: width_sel = $urandom_range(13, 40);
                4: width_sel = $urandom_range(513, 1023);
                default: width_sel = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                0: height_sel = $urandom_range(0, 1);
                1: height_sel = $urandom_range(513, 1023);
                default: height_sel = $urandom_range(2, 6);
            endcase
            pick_idling();
            write_sizes(width_sel, height_sel);
            phase_len = $urandom_range(20, 60);
            for (int i = 0; i < phase_len; i++)
                send_pixel(random_colour(),
                           (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0));
            settle();
        end

        $display("%0d map pixels over %0d size settings, %0d output rows checked",
                 pixels_sent, size_settings, sb.rows_checked);
        $display("%0d field mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("bilinear_upscale_4x4_blit_unit_tb: PASS");
        else
            $display("bilinear_upscale_4x4_blit_unit_tb: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d output rows outstanding", sb.pending());
        $display("bilinear_upscale_4x4_blit_unit_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/bup4_pkg.sv
sv/bilinear_upscale_4x4_blit_unit.sv
sv/bup4_checker.sv
tb/sv/bilinear_upscale_4x4_blit_unit_tb.sv
